// ===== rtl/core/bldc_six_step_commutator_unit_macros.svh =====
// Assertion macros shared by the commutator RTL.
`ifndef BLDC_SIX_STEP_COMMUTATOR_UNIT_MACROS_SVH
`define BLDC_SIX_STEP_COMMUTATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bsc_pkg.sv =====
`timescale 1ns / 1ps

package bsc_pkg;

    // Default commutation counter width.
    localparam int BSC_COUNT_BITS = 16;

    // Reset values of the configuration registers.
    localparam logic [7:0] PWM_PERIOD_RESET      = 8'd249;
    localparam logic [6:0] CLAMP_THRESHOLD_RESET = 7'd15;

    // Input item kinds.
    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_ZC   = 2'd1;
    localparam logic [1:0] KIND_DUTY = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_PWM_PERIOD      = 1'b0;
    localparam logic CFG_CLAMP_THRESHOLD = 1'b1;

    // Last step of the six-step sequence.
    localparam logic [2:0] STEP_LAST = 3'd5;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] duty_request;
    } in_item_t;

    typedef struct packed {
        logic [5:0] gate_pattern;
        logic [2:0] step_index;
        logic [1:0] sense_phase;
        logic       sense_rising;
        logic       motor_on;
        logic       full_on;
        logic       committed_step;
    } out_item_t;

    typedef struct packed {
        logic [7:0] pwm_period;
        logic [6:0] clamp_threshold;
    } cfg_t;

    // Bridge switch enables for each step.
    function automatic logic [5:0] step_gates(input logic [2:0] step);
        logic [5:0] gates;
        case (step)
            3'd0:    gates = 6'h24;
            3'd1:    gates = 6'h21;
            3'd2:    gates = 6'h09;
            3'd3:    gates = 6'h18;
            3'd4:    gates = 6'h12;
            3'd5:    gates = 6'h06;
            default: gates = 6'h00;
        endcase
        return gates;
    endfunction

    // Floating phase watched for back-EMF in each step.
    function automatic logic [1:0] step_phase(input logic [2:0] step);
        logic [1:0] phase;
        case (step)
            3'd0, 3'd3: phase = 2'd2;
            3'd1, 3'd4: phase = 2'd1;
            default:    phase = 2'd0;
        endcase
        return phase;
    endfunction

    // Expected crossing direction: odd steps look for a rising edge.
    function automatic logic step_edge(input logic [2:0] step);
        return step[0];
    endfunction

endpackage

// ===== rtl/core/bsc_engine.sv =====
`timescale 1ns / 1ps

module bsc_engine
    import bsc_pkg::*;
#(
    parameter int COUNT_BITS = BSC_COUNT_BITS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      fire,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [2:0]            step_reg, step_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [COUNT_BITS-1:0] top_reg, top_next;
    logic [7:0]            pwm_count_reg, pwm_count_next;
    logic                  pwm_rising_reg, pwm_rising_next;
    logic [7:0]            duty_reg, duty_next;
    logic                  enabled_reg, enabled_next;
    logic                  full_reg, full_next;
    logic                  committed;
    logic [COUNT_BITS-1:0] count_inc;
    logic                  duty_low;
    logic                  duty_high;
    logic [5:0]            gates;

    // Saturating tick count and duty clamp compares.
    always_comb begin
        count_inc = (count_reg != COUNT_MAX) ? count_reg + 1'b1 : count_reg;
        duty_low  = item.duty_request < {1'b0, cfg.clamp_threshold};
        duty_high = ({1'b0, item.duty_request} + {2'b00, cfg.clamp_threshold})
                    >= {1'b0, cfg.pwm_period};
    end

    // Next state for the item in flight.
    always_comb begin
        step_next       = step_reg;
        count_next      = count_reg;
        top_next        = top_reg;
        pwm_count_next  = pwm_count_reg;
        pwm_rising_next = pwm_rising_reg;
        duty_next       = duty_reg;
        enabled_next    = enabled_reg;
        full_next       = full_reg;
        committed       = 1'b0;

        unique case (item.kind)
            KIND_TICK: begin
                if (enabled_reg) begin
                    // Triangle counter turns at the period and at zero.
                    if (pwm_rising_reg) begin
                        if (pwm_count_reg >= cfg.pwm_period) begin
                            pwm_rising_next = 1'b0;
                            if (pwm_count_reg != 8'd0) begin
                                pwm_count_next = pwm_count_reg - 1'b1;
                            end
                        end else begin
                            pwm_count_next = pwm_count_reg + 1'b1;
                        end
                    end else begin
                        if (pwm_count_reg == 8'd0) begin
                            pwm_rising_next = 1'b1;
                            if (cfg.pwm_period != 8'd0) begin
                                pwm_count_next = 8'd1;
                            end
                        end else begin
                            pwm_count_next = pwm_count_reg - 1'b1;
                        end
                    end
                    // Commutate when the count reaches the top.
                    if (count_inc >= top_reg) begin
                        step_next  = (step_reg >= STEP_LAST) ? 3'd0 : step_reg + 1'b1;
                        count_next = '0;
                        top_next   = COUNT_MAX;
                        committed  = 1'b1;
                    end else begin
                        count_next = count_inc;
                    end
                end
            end
            KIND_ZC: begin
                // The next step comes after twice the time since the last one.
                if (enabled_reg) begin
                    top_next = count_reg[COUNT_BITS-1] ? COUNT_MAX
                             : {count_reg[COUNT_BITS-2:0], 1'b0};
                end
            end
            KIND_DUTY: begin
                if (duty_low) begin
                    duty_next    = 8'd0;
                    full_next    = 1'b0;
                    enabled_next = 1'b0;
                end else begin
                    // Starting from off restarts both counters.
                    if (!enabled_reg) begin
                        count_next      = '0;
                        top_next        = COUNT_MAX;
                        pwm_count_next  = 8'd0;
                        pwm_rising_next = 1'b1;
                        enabled_next    = 1'b1;
                    end
                    duty_next = duty_high ? cfg.pwm_period : item.duty_request;
                    full_next = duty_high;
                end
            end
            default: begin
            end
        endcase
    end

    // Result from the updated state.
    always_comb begin
        if (!enabled_next) begin
            gates = 6'h00;
        end else if (full_next || (pwm_count_next < duty_next)) begin
            gates = step_gates(step_next);
        end else begin
            gates = 6'h00;
        end
        result.gate_pattern   = gates;
        result.step_index     = step_next;
        result.sense_phase    = step_phase(step_next);
        result.sense_rising   = step_edge(step_next);
        result.motor_on       = enabled_next;
        result.full_on        = full_next;
        result.committed_step = committed;
    end

    // State registers update once per processed beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg       <= 3'd0;
            count_reg      <= '0;
            top_reg        <= COUNT_MAX;
            pwm_count_reg  <= 8'd0;
            pwm_rising_reg <= 1'b1;
            duty_reg       <= 8'd0;
            enabled_reg    <= 1'b0;
            full_reg       <= 1'b0;
        end else if (fire) begin
            step_reg       <= step_next;
            count_reg      <= count_next;
            top_reg        <= top_next;
            pwm_count_reg  <= pwm_count_next;
            pwm_rising_reg <= pwm_rising_next;
            duty_reg       <= duty_next;
            enabled_reg    <= enabled_next;
            full_reg       <= full_next;
        end
    end

endmodule

// ===== rtl/core/bldc_six_step_commutator_unit.sv =====
// Sensorless six-step BLDC commutator.
// Input channel s_*: one beat per event, a timer tick, a back-EMF
// zero-crossing or a throttle duty command (s_data.kind selects which).
// Result channel m_*: exactly one beat per input beat, in order, carrying the
// gate pattern, the step, the phase and edge to sense, and motor status.
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_index
// (0 PWM period, 1 clamp threshold); write only while the block is idle.
// Flow: an accepted beat sits in the input register and is processed there
// once the result register is free or is being taken; its result is loaded
// into the result register, which drives m_data until it is taken. Throughput
// is one beat per cycle while m_ready stays high; the state update from the
// input register into the result register sets this figure.
// Reset (aresetn low, synchronous) disables the motor, returns to step 0,
// restores the register defaults and empties both registers.
// When m_ready is low the result register holds, the input register still
// takes one more beat, and then s_ready drops until the result is taken.
`timescale 1ns / 1ps
`include "bldc_six_step_commutator_unit_macros.svh"

module bldc_six_step_commutator_unit
    import bsc_pkg::*;
#(
    parameter int COUNT_BITS = BSC_COUNT_BITS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data,
    input  logic      cfg_wr_en,
    input  logic      cfg_index,
    input  logic [7:0] cfg_wdata
);

    cfg_t      cfg_reg;
    in_item_t  in_item_reg;
    logic      in_valid_reg;
    out_item_t out_item_reg;
    logic      out_valid_reg;
    out_item_t result;
    logic      fire;

    // Process the held beat whenever the result register is free.
    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;
    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pwm_period      <= PWM_PERIOD_RESET;
            cfg_reg.clamp_threshold <= CLAMP_THRESHOLD_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_PWM_PERIOD:      cfg_reg.pwm_period      <= cfg_wdata;
                CFG_CLAMP_THRESHOLD: cfg_reg.clamp_threshold <= cfg_wdata[6:0];
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    // State update and result logic.
    bsc_engine #(
        .COUNT_BITS (COUNT_BITS)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= fire || (out_valid_reg && !m_ready);
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_item_reg <= result;
        end
    end

    `BSC_ASSERT_NEXT(a_accept_held, s_valid && s_ready, in_valid_reg, "accepted beat not held")
    `BSC_ASSERT_NEXT(a_stall_keeps_input, in_valid_reg && out_valid_reg && !m_ready,
        in_valid_reg, "held beat lost during stall")
    `BSC_ASSERT_NEXT(a_fire_gives_result, fire, out_valid_reg, "processed beat gave no result")
    `BSC_ASSERT_NOW(a_off_gates_zero, m_valid && !m_data.motor_on,
        m_data.gate_pattern == 6'h00 && !m_data.full_on, "gates driven while motor off")
    `BSC_ASSERT_NOW(a_commit_needs_motor, m_valid && m_data.committed_step,
        m_data.motor_on && m_data.step_index <= STEP_LAST, "step advanced while motor off")

endmodule
